>>> hw/rtl/aeg_pkg.sv
// aeg_pkg: shared codes and fixed widths for the adsr envelope gain block
// no dependencies; imported by the top level, both checkers and the testbench

package aeg_pkg;

  // item kinds carried in the input tuser
  localparam int unsigned FUNC_W = 2;
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GATE_ON  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_GATE_OFF = 2'd2;

  // envelope stages, also reported in the output tuser
  localparam int unsigned STAGE_W = 3;
  localparam logic [STAGE_W-1:0] STG_OFF     = 3'd0;
  localparam logic [STAGE_W-1:0] STG_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] STG_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] STG_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] STG_RELEASE = 3'd4;

  // gain is q1.16
  localparam int unsigned GAIN_W = 17;
  localparam int unsigned FRAC_W = 16;
  localparam logic [GAIN_W-1:0] UNITY = 17'h10000;

  // configuration registers
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_TIME_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

  localparam logic [CFG_TIME_W-1:0] RST_ATTACK  = 16'd480;
  localparam logic [CFG_TIME_W-1:0] RST_DECAY   = 16'd4800;
  localparam logic [GAIN_W-1:0]     RST_SUSTAIN = 17'd49152;
  localparam logic [CFG_TIME_W-1:0] RST_RELEASE = 16'd9600;

endpackage

>>> hw/rtl/aeg_mul.sv
// aeg_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; no package dependencies

module aeg_mul #(
  parameter int unsigned A_W = 16,
  parameter int unsigned B_W = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [A_W-1:0]     a_i,
  input  logic        [B_W-1:0]     b_i,
  output logic                      done_o,
  output logic signed [A_W+B_W-1:0] prod_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [P_W-1:0]   mcand_q;
  logic [B_W-1:0]          mplier_q;
  logic signed [P_W-1:0]   acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(B_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial products wrap modulo 2^P_W, which keeps two's complement exact
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= P_W'(a_i);
      mplier_q <= b_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> hw/rtl/aeg_div.sv
// aeg_div: restoring divider, one quotient bit per cycle
// caller guarantees the quotient fits in Q_W bits; no package dependencies

module aeg_div #(
  parameter int unsigned D_W = 16,
  parameter int unsigned Q_W = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [D_W+Q_W-1:0]   num_i,
  input  logic [D_W-1:0]       den_i,
  output logic                 done_o,
  output logic [Q_W-1:0]       quo_o
);

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [D_W-1:0]   rem_q;
  logic [D_W-1:0]   den_q;
  logic [Q_W-1:0]   lo_q;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             ge;

  assign trial = {rem_q, lo_q[Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(Q_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend low bits shift out at the top while quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[D_W+Q_W-1:Q_W];
      lo_q  <= num_i[Q_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      lo_q  <= {lo_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = lo_q;

endmodule

>>> hw/rtl/adsr_envelope_gain.sv
// adsr_envelope_gain: linear adsr envelope applied to a sample stream
// uses aeg_pkg, aeg_mul (bit-serial multiply) and aeg_div (restoring divide)
//
// Usage: the input stream carries one item per request. s_axis_tuser says what
// it is: an audio sample (sample in s_axis_tdata), gate on or gate off. Gate
// items change the envelope state and produce nothing. Each sample produces
// one output request: the sample times the current gain, floored, with the
// stage that gave the gain in m_axis_tuser.
// Path per sample, accept to output valid:
//   sustain / off : serial sample multiply only
//   attack        : serial divide, then multiply
//   decay/release : gain multiply, divide, multiply
// The serial units handle one item at a time, so the next sample is taken once
// the previous one has reached the output register. The output register holds
// a finished result while the receiver stalls, and the block meanwhile accepts
// the next item; a second result waits in the multiplier until the register
// frees.
// Reset (asynchronous, active low) loads the default times and sustain level
// and puts the envelope in the off stage.

module adsr_envelope_gain #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned TIME_WIDTH   = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [aeg_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [aeg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // sample_in
  input  logic [aeg_pkg::FUNC_W-1:0]          s_axis_tuser,  // func
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // sample_out
  output logic [aeg_pkg::STAGE_W-1:0]         m_axis_tuser   // stage_out
);

  import aeg_pkg::*;

  localparam int unsigned TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned N_W     = TIME_WIDTH + GAIN_W;
  localparam int unsigned M1_A_W  = GAIN_W + 1;
  localparam logic [31:0] TIME_MAX32 = (32'd1 << TIME_WIDTH) - 32'd1;

  localparam logic [2:0] CS_IDLE = 3'd0;
  localparam logic [2:0] CS_MUL1 = 3'd1;
  localparam logic [2:0] CS_DIV  = 3'd2;
  localparam logic [2:0] CS_MUL2 = 3'd3;
  localparam logic [2:0] CS_HOLD = 3'd4;

  function automatic logic [TIME_WIDTH-1:0] eff_time(input logic [CFG_TIME_W-1:0] t);
    logic [31:0] v;
    v = 32'(t);
    if (v == 32'd0) v = 32'd1;
    if (v > TIME_MAX32) v = TIME_MAX32;
    return v[TIME_WIDTH-1:0];
  endfunction

  // config registers
  logic [CFG_TIME_W-1:0] attack_q, decay_q, release_q;
  logic [GAIN_W-1:0]     sustain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= RST_ATTACK;
      decay_q   <= RST_DECAY;
      sustain_q <= RST_SUSTAIN;
      release_q <= RST_RELEASE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATTACK:  attack_q  <= cfg_data_i[CFG_TIME_W-1:0];
        REG_DECAY:   decay_q   <= cfg_data_i[CFG_TIME_W-1:0];
        REG_SUSTAIN: sustain_q <= cfg_data_i;
        REG_RELEASE: release_q <= cfg_data_i[CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

  logic [TIME_WIDTH-1:0] a_eff, d_eff, r_eff;
  logic [GAIN_W-1:0]     s_eff;

  assign a_eff = eff_time(attack_q);
  assign d_eff = eff_time(decay_q);
  assign r_eff = eff_time(release_q);
  assign s_eff = (sustain_q > UNITY) ? UNITY : sustain_q;

  // envelope state
  logic [STAGE_W-1:0]    stage_q, stage_d;
  logic [TIME_WIDTH-1:0] time_left_q, time_left_d;
  logic [TIME_WIDTH-1:0] left_a, left_d, left_r, tl_dec;

  assign left_a = (time_left_q > a_eff) ? a_eff : time_left_q;
  assign left_d = (time_left_q > d_eff) ? d_eff : time_left_q;
  assign left_r = (time_left_q > r_eff) ? r_eff : time_left_q;
  assign tl_dec = (time_left_q == '0) ? '0 : time_left_q - TIME_WIDTH'(1);

  // sequencer
  logic [2:0]               ctrl_q, ctrl_d;
  logic [TIME_WIDTH-1:0]    den_q, den_d;
  logic                     add_s_q, add_s_d;
  logic [STAGE_W-1:0]       used_q, used_d;
  logic signed [SAMPLE_WIDTH-1:0] sample_q, sample_d;

  logic                     accept;
  logic signed [SAMPLE_WIDTH-1:0] smp_in;
  logic                     out_free, out_load;

  logic                         mul1_start, mul1_done;
  logic [GAIN_W-1:0]            mul1_a;
  logic [TIME_WIDTH-1:0]        mul1_b;
  logic signed [M1_A_W+TIME_WIDTH-1:0] mul1_prod;

  logic                         div_start, div_done;
  logic [N_W-1:0]               div_num;
  logic [TIME_WIDTH-1:0]        div_den;
  logic [GAIN_W-1:0]            div_quo;

  logic                         mul2_start, mul2_done;
  logic signed [SAMPLE_WIDTH-1:0] mul2_a;
  logic [GAIN_W-1:0]            mul2_b;
  logic signed [SAMPLE_WIDTH+GAIN_W-1:0] mul2_prod;

  assign s_axis_tready = (ctrl_q == CS_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign smp_in        = s_axis_tdata[SAMPLE_WIDTH-1:0];

  logic m_valid_q;
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    stage_d     = stage_q;
    time_left_d = time_left_q;
    ctrl_d      = ctrl_q;
    den_d       = den_q;
    add_s_d     = add_s_q;
    used_d      = used_q;
    sample_d    = sample_q;
    out_load    = 1'b0;
    mul1_start  = 1'b0;
    mul1_a      = '0;
    mul1_b      = '0;
    div_start   = 1'b0;
    div_num     = mul1_prod[N_W-1:0];
    div_den     = den_q;
    mul2_start  = 1'b0;
    mul2_a      = sample_q;
    mul2_b      = div_quo + (add_s_q ? s_eff : '0);

    unique case (ctrl_q)
      CS_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            FUNC_GATE_ON: begin
              stage_d     = STG_ATTACK;
              time_left_d = a_eff;
            end
            FUNC_GATE_OFF: begin
              stage_d     = STG_RELEASE;
              time_left_d = r_eff;
            end
            FUNC_SAMPLE: begin
              sample_d = smp_in;
              used_d   = stage_q;
              unique case (stage_q)
                STG_ATTACK: begin
                  // gain = (a - left) * 2^16 / a
                  div_start = 1'b1;
                  div_num   = N_W'({a_eff - left_a, FRAC_W'(0)});
                  div_den   = a_eff;
                  add_s_d   = 1'b0;
                  ctrl_d    = CS_DIV;
                  if (tl_dec == '0) begin
                    stage_d     = STG_DECAY;
                    time_left_d = d_eff;
                  end else begin
                    time_left_d = tl_dec;
                  end
                end
                STG_DECAY: begin
                  // gain = s + (1 - s) * left / d
                  mul1_start  = 1'b1;
                  mul1_a      = UNITY - s_eff;
                  mul1_b      = left_d;
                  den_d       = d_eff;
                  add_s_d     = 1'b1;
                  ctrl_d      = CS_MUL1;
                  time_left_d = tl_dec;
                  if (tl_dec == '0) stage_d = STG_SUSTAIN;
                end
                STG_RELEASE: begin
                  // gain = s * left / r
                  mul1_start  = 1'b1;
                  mul1_a      = s_eff;
                  mul1_b      = left_r;
                  den_d       = r_eff;
                  add_s_d     = 1'b0;
                  ctrl_d      = CS_MUL1;
                  time_left_d = tl_dec;
                  if (tl_dec == '0) stage_d = STG_OFF;
                end
                STG_SUSTAIN: begin
                  mul2_start = 1'b1;
                  mul2_a     = smp_in;
                  mul2_b     = s_eff;
                  ctrl_d     = CS_MUL2;
                end
                default: begin
                  used_d     = STG_OFF;
                  mul2_start = 1'b1;
                  mul2_a     = smp_in;
                  mul2_b     = '0;
                  ctrl_d     = CS_MUL2;
                end
              endcase
            end
            default: ;
          endcase
        end
      end
      CS_MUL1: begin
        if (mul1_done) begin
          div_start = 1'b1;
          ctrl_d    = CS_DIV;
        end
      end
      CS_DIV: begin
        if (div_done) begin
          mul2_start = 1'b1;
          ctrl_d     = CS_MUL2;
        end
      end
      CS_MUL2: begin
        if (mul2_done) begin
          if (out_free) begin
            out_load = 1'b1;
            ctrl_d   = CS_IDLE;
          end else begin
            ctrl_d = CS_HOLD;
          end
        end
      end
      CS_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          ctrl_d   = CS_IDLE;
        end
      end
      default: ctrl_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= CS_IDLE;
      stage_q     <= STG_OFF;
      time_left_q <= '0;
    end else begin
      ctrl_q      <= ctrl_d;
      stage_q     <= stage_d;
      time_left_q <= time_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q    <= den_d;
    add_s_q  <= add_s_d;
    used_q   <= used_d;
    sample_q <= sample_d;
  end

  aeg_mul #(
    .A_W (M1_A_W),
    .B_W (TIME_WIDTH)
  ) u_gain_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul1_start),
    .a_i     ($signed({1'b0, mul1_a})),
    .b_i     (mul1_b),
    .done_o  (mul1_done),
    .prod_o  (mul1_prod)
  );

  aeg_div #(
    .D_W (TIME_WIDTH),
    .Q_W (GAIN_W)
  ) u_gain_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  aeg_mul #(
    .A_W (SAMPLE_WIDTH),
    .B_W (GAIN_W)
  ) u_sample_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul2_start),
    .a_i     (mul2_a),
    .b_i     (mul2_b),
    .done_o  (mul2_done),
    .prod_o  (mul2_prod)
  );

  // output register
  logic [SAMPLE_WIDTH-1:0] m_data_q;
  logic [STAGE_W-1:0]      m_stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // arithmetic shift by the fraction width floors the product
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q  <= mul2_prod[FRAC_W +: SAMPLE_WIDTH];
      m_stage_q <= used_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'(m_data_q);
  assign m_axis_tuser  = m_stage_q;

endmodule

>>> hw/rtl/aeg_checker.sv
// aeg_checker: port-level assertions for adsr_envelope_gain
// uses aeg_pkg; attached to the top level by the bind at the end of this file

module aeg_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [aeg_pkg::FUNC_W-1:0]        s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input logic [aeg_pkg::STAGE_W-1:0]       m_axis_tuser
);

  import aeg_pkg::*;

  // a stalled output request keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output request changed while stalled");

  // a sample occupies the serial units, so input is closed the next cycle
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_SAMPLE |=> !s_axis_tready)
    else $error("input ready right after a sample");

  // a gate or unknown item leaves input ready the next cycle
  a_gate_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != FUNC_SAMPLE |=> s_axis_tready)
    else $error("input stalled after a gate item");

  // off stage means zero gain
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == STG_OFF |-> m_axis_tdata == '0)
    else $error("nonzero output in off stage");

endmodule

bind adsr_envelope_gain aeg_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_aeg_checker (.*);

>>> sim/aeg_stream_checker.sv
// aeg_stream_checker: watches the config port and both streams of adsr_envelope_gain,
// predicts each scaled sample and compares it in order with what comes out
// uses aeg_pkg; instantiated beside the block by tb_adsr_envelope_gain

module aeg_stream_checker
  import aeg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [15:0]           s_tdata_i,   // sample_in
  input  logic [FUNC_W-1:0]     s_tuser_i,   // func
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [15:0]           m_tdata_i,   // sample_out
  input  logic [STAGE_W-1:0]    m_tuser_i,   // stage_out
  output int unsigned           fail_cnt_o,
  output int unsigned           checked_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [15:0]        sample;
    logic [STAGE_W-1:0] stage;
  } scaled_sample_t;

  // mirrored settings and envelope state
  logic [CFG_TIME_W-1:0] atk_len, dec_len, rel_len;
  logic [GAIN_W-1:0]     sus_lvl;
  logic [STAGE_W-1:0]    stage_q;
  logic [15:0]           left_q;

  scaled_sample_t scaled_sample_q[$];
  int unsigned n_fail    = 0;
  int unsigned n_checked = 0;

  assign fail_cnt_o = n_fail;
  assign checked_o  = n_checked;

  // true once the counting stage has run out
  function automatic bit tick_down();
    if (left_q != '0) left_q = left_q - 1'b1;
    return left_q == '0;
  endfunction

  function automatic bit apply_envelope(input logic [FUNC_W-1:0] kind,
                                        input logic signed [15:0] smp,
                                        output scaled_sample_t res);
    longint unsigned a, d, r, s, left, gain;
    longint prod;
    // zero lengths behave as one sample, sustain saturates at unity
    a = (atk_len == '0) ? 64'd1 : 64'(atk_len);
    d = (dec_len == '0) ? 64'd1 : 64'(dec_len);
    r = (rel_len == '0) ? 64'd1 : 64'(rel_len);
    s = (sus_lvl > UNITY) ? 64'(UNITY) : 64'(sus_lvl);
    res = '0;
    if (kind == FUNC_GATE_ON) begin
      stage_q = STG_ATTACK;
      left_q  = a[15:0];
      return 1'b0;
    end
    if (kind == FUNC_GATE_OFF) begin
      stage_q = STG_RELEASE;
      left_q  = r[15:0];
      return 1'b0;
    end
    if (kind != FUNC_SAMPLE) return 1'b0;
    res.stage = stage_q;
    gain = 0;
    case (stage_q)
      STG_ATTACK: begin
        left = (left_q > a) ? a : 64'(left_q);
        gain = ((a - left) << FRAC_W) / a;
        if (tick_down()) begin
          stage_q = STG_DECAY;
          left_q  = d[15:0];
        end
      end
      STG_DECAY: begin
        left = (left_q > d) ? d : 64'(left_q);
        gain = s + ((64'(UNITY) - s) * left) / d;
        if (tick_down()) stage_q = STG_SUSTAIN;
      end
      STG_SUSTAIN: gain = s;
      STG_RELEASE: begin
        // release always ramps down from the sustain level
        left = (left_q > r) ? r : 64'(left_q);
        gain = (s * left) / r;
        if (tick_down()) stage_q = STG_OFF;
      end
      default: res.stage = STG_OFF;
    endcase
    prod = longint'(smp) * longint'(gain);
    // bit slice of the two's complement product is the floored shift
    res.sample = prod[31:16];
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    scaled_sample_t want, got;
    if (!rst_ni) begin
      atk_len   = RST_ATTACK;
      dec_len   = RST_DECAY;
      sus_lvl   = RST_SUSTAIN;
      rel_len   = RST_RELEASE;
      stage_q   = STG_OFF;
      left_q    = '0;
      scaled_sample_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ATTACK:  atk_len = cfg_data_i[CFG_TIME_W-1:0];
          REG_DECAY:   dec_len = cfg_data_i[CFG_TIME_W-1:0];
          REG_SUSTAIN: sus_lvl = cfg_data_i[GAIN_W-1:0];
          REG_RELEASE: rel_len = cfg_data_i[CFG_TIME_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        got.sample = m_tdata_i;
        got.stage  = m_tuser_i;
        if (scaled_sample_q.size() == 0) begin
          n_fail++;
          $error("unexpected output request: sample_out %0d stage_out %0d",
                 $signed(got.sample), got.stage);
        end else begin
          want = scaled_sample_q.pop_front();
          n_checked++;
          if (got.sample !== want.sample) begin
            n_fail++;
            $error("sample_out mismatch: expected %0d, actual %0d",
                   $signed(want.sample), $signed(got.sample));
          end
          if (got.stage !== want.stage) begin
            n_fail++;
            $error("stage_out mismatch: expected %0d, actual %0d", want.stage, got.stage);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (apply_envelope(s_tuser_i, s_tdata_i, want)) scaled_sample_q.push_back(want);
      end
      pending_o <= scaled_sample_q.size();
    end
  end

endmodule

>>> sim/tb_adsr_envelope_gain.sv
// tb_adsr_envelope_gain: drives gate and sample requests and envelope settings
// into adsr_envelope_gain, with random idling and one long output stall
// uses aeg_pkg and aeg_stream_checker, which predicts and compares the results

module tb_adsr_envelope_gain;
  import aeg_pkg::*;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned ITEM_TARGET = 390;
  localparam int unsigned DRAIN       = 64;
  localparam int unsigned LIMIT       = 400000;
  localparam int unsigned HOLD_AT     = 120;
  localparam int unsigned HOLD_LEN    = 600;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata;  // sample_in
  logic [FUNC_W-1:0]     s_axis_tuser;  // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [DATA_W-1:0]     m_axis_tdata;  // sample_out
  logic [STAGE_W-1:0]    m_axis_tuser;  // stage_out

  int unsigned fail_cnt, checked_cnt, busy_cnt;
  int unsigned n_items    = 0;
  int unsigned n_settings = 0;
  int unsigned n_taken    = 0;
  int unsigned cycle_cnt  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  adsr_envelope_gain u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  aeg_stream_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .fail_cnt_o (fail_cnt),
    .checked_o  (checked_cnt),
    .pending_o  (busy_cnt)
  );

  function automatic logic [CFG_TIME_W-1:0] pick_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return CFG_TIME_W'($urandom_range(1, 65535));
      default: return CFG_TIME_W'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_sustain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return UNITY;
      2:       return GAIN_W'($urandom_range(65537, 131071));
      default: return GAIN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [FUNC_W-1:0] kind, input logic [DATA_W-1:0] data);
    // one stretch of requests goes out back to back
    while (!(n_items >= 250 && n_items < 330) && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
  endtask

  // wait for every predicted sample, then let any gate request finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (busy_cnt != 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_envelope(input logic [CFG_TIME_W-1:0] atk, input logic [CFG_TIME_W-1:0] dec,
                               input logic [GAIN_W-1:0] sus, input logic [CFG_TIME_W-1:0] rel);
    write_reg(REG_ATTACK, CFG_DATA_W'(atk));
    write_reg(REG_DECAY, CFG_DATA_W'(dec));
    write_reg(REG_SUSTAIN, CFG_DATA_W'(sus));
    write_reg(REG_RELEASE, CFG_DATA_W'(rel));
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  // output side: random stalls, one quiet window and one long hold-off
  initial begin : receiver
    bit held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) n_taken++;
      // start the hold-off while the sender is offering, so the block backs up
      if (!held && n_taken >= HOLD_AT && s_axis_tvalid) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else begin
        m_axis_tready <= (n_taken >= 200 && n_taken < 280) || ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_TIME_W-1:0] ta, td, tr;
    int unsigned span;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_ATTACK;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_SAMPLE;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: off stage, gate off from off, ignored code, attack start
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_GATE_OFF, 16'h0000);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'hFFFF);
    send_item(FUNC_W'(3), 16'h5A5A);
    send_item(FUNC_GATE_ON, 16'hFFFF);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    settle();

    // attack shortened mid stage, zero decay, sustain above unity, longest release
    load_envelope(16'd2, 16'd0, 17'h1FFFF, 16'hFFFF);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_GATE_ON, 16'h0000);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_SAMPLE, 16'h5555);
    send_item(FUNC_GATE_OFF, 16'h0000);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    settle();

    // longest attack and decay, zero sustain, one-sample release
    load_envelope(16'hFFFF, 16'hFFFF, 17'd0, 16'd1);
    send_item(FUNC_GATE_ON, 16'h0000);
    send_item(FUNC_SAMPLE, 16'hAAAA);
    send_item(FUNC_GATE_OFF, 16'h0000);
    send_item(FUNC_SAMPLE, 16'h7FFF);
    send_item(FUNC_SAMPLE, 16'h8000);
    send_item(FUNC_GATE_OFF, 16'h0000);
    send_item(FUNC_SAMPLE, 16'h1234);
    settle();

    // random part: notes with random content under random settings, some noise
    while (n_items < ITEM_TARGET) begin
      ta = pick_time();
      td = pick_time();
      tr = pick_time();
      load_envelope(ta, td, pick_sustain(), tr);
      repeat ($urandom_range(2, 5)) begin
        if ($urandom_range(99) < 20) begin
          repeat ($urandom_range(1, 3)) send_item(FUNC_W'($urandom_range(3)), DATA_W'($urandom));
        end
        send_item(FUNC_GATE_ON, DATA_W'($urandom));
        span = int'(ta) + int'(td) + 4;
        if (span > 40) span = 40;
        repeat ($urandom_range(0, span)) send_item(FUNC_SAMPLE, pick_sample());
        if ($urandom_range(99) < 80) begin
          send_item(FUNC_GATE_OFF, DATA_W'($urandom));
          span = int'(tr) + 3;
          if (span > 30) span = 30;
          repeat ($urandom_range(0, span)) send_item(FUNC_SAMPLE, pick_sample());
        end
      end
      settle();
    end

    $display("covered %0d requests under %0d envelope settings, %0d scaled samples compared",
             n_items, n_settings, checked_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
